@@ hw/rtl/rgbfb_pkg.sv @@
package rgbfb_pkg;

  // Register widths
  localparam int WIDTH_W   = 13;
  localparam int PITCH_W   = 15;
  localparam int FMT_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // Payload widths
  localparam int COLOR_W   = 8;
  localparam int OFFSET_W  = 26;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;

  // Format field layout: length in bits 9..5, offset in bits 4..0
  localparam int LEN_W     = 5;
  localparam int OFF_W     = 5;
  localparam int MAX_LEN   = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPP_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FORMAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FORMAT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FORMAT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FORMAT  = 3'd7;

  typedef struct packed {
    logic [WIDTH_W-1:0] screen_width;
    logic [WIDTH_W-1:0] screen_height;
    logic [PITCH_W-1:0] line_pitch;
    logic               bpp_mode;
    logic [FMT_W-1:0]   red_format;
    logic [FMT_W-1:0]   green_format;
    logic [FMT_W-1:0]   blue_format;
    logic [FMT_W-1:0]   alpha_format;
  } cfg_t;

  // Bit length of a format, saturated to sixteen
  function automatic logic [LEN_W-1:0] fmt_len(input logic [FMT_W-1:0] fmt);
    logic [LEN_W-1:0] len;
    len = fmt[FMT_W-1:OFF_W];
    return (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
  endfunction

  function automatic logic [OFF_W-1:0] fmt_off(input logic [FMT_W-1:0] fmt);
    return fmt[OFF_W-1:0];
  endfunction

endpackage

@@ hw/rtl/rgbfb_cfg.sv @@
module rgbfb_cfg import rgbfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  // Decode the index and update one register per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[WIDTH_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[WIDTH_W-1:0];
        REG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data_i[PITCH_W-1:0];
        REG_BPP_MODE:      cfg_q.bpp_mode      <= cfg_data_i[0];
        REG_RED_FORMAT:    cfg_q.red_format    <= cfg_data_i[FMT_W-1:0];
        REG_GREEN_FORMAT:  cfg_q.green_format  <= cfg_data_i[FMT_W-1:0];
        REG_BLUE_FORMAT:   cfg_q.blue_format   <= cfg_data_i[FMT_W-1:0];
        REG_ALPHA_FORMAT:  cfg_q.alpha_format  <= cfg_data_i[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/rgbfb_chan.sv @@
module rgbfb_chan import rgbfb_pkg::*; (
  input  logic [COLOR_W-1:0] value_i,
  input  logic [FMT_W-1:0]   fmt_i,
  output logic [WORD_W-1:0]  placed_o
);

  localparam int NUM_W  = COLOR_W + MAX_LEN;   // v*(2^len-1)+127 fits here
  localparam int PROD_W = 2 * NUM_W + 1;
  localparam int SH_W   = HALF_W + WORD_W - 1;

  logic [LEN_W-1:0]  len;
  logic [OFF_W-1:0]  off;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [HALF_W-1:0] scaled;
  logic [SH_W-1:0]   shifted;

  assign len = fmt_len(fmt_i);
  assign off = fmt_off(fmt_i);

  // Rescale with rounding: v*(2^len-1) + 127; zero length leaves only 127
  assign num = (NUM_W'(value_i) << len) - NUM_W'(value_i) + NUM_W'(127);

  // Divide by 255: multiply by 0x01010102 and keep the bits above 2^32
  assign prod = (PROD_W'(num) << 24) + (PROD_W'(num) << 16)
              + (PROD_W'(num) << 8) + (PROD_W'(num) << 1);
  assign scaled = prod[WORD_W+HALF_W-1:WORD_W];

  // Move to the bit offset, drop anything past bit 31
  assign shifted  = SH_W'(scaled) << off;
  assign placed_o = shifted[WORD_W-1:0];

endmodule

@@ hw/rtl/rgb888_to_framebuffer_packer_top.sv @@
// RGB888 to framebuffer pixel packer.
// Input channel: in_valid_i / in_stall_o carry one pixel (column, row and
// 8-bit red, green, blue) per transfer. Output channel: out_valid_o /
// out_stall_i carry the packed word, its framebuffer byte offset and the
// four-byte flag. Pixels outside the configured screen give no output.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_index_i;
// write only while no pixel is in flight.
// Pipeline: a pixel passes through two register stages, the input register
// and then the result register.
// Throughput: one pixel per cycle while the output is not stalled; the scaling,
// packing and offset multiply all sit between the two register stages.
// Stall: while the output holds a result and out_stall_i is high, that
// result stays put; the input register still fills, and in_stall_o rises
// only once it is full as well.
// Reset: all configuration registers clear to zero (every pixel dropped
// until the screen size is set) and both stages empty.
module rgb888_to_framebuffer_packer_top import rgbfb_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OFFSET_W-1:0]   byte_offset_o,
  output logic [WORD_W-1:0]     packed_pixel_o,
  output logic                  four_bytes_o
);

  localparam int CMP_W = (COORD_BITS > WIDTH_W) ? COORD_BITS : WIDTH_W;
  localparam int SUM_W = (COORD_BITS + PITCH_W > OFFSET_W) ?
                         COORD_BITS + PITCH_W + 1 : OFFSET_W + 1;
  localparam int SH_W  = HALF_W + WORD_W - 1;

  cfg_t cfg;

  rgbfb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register stage
  logic                  s1_valid_q;
  logic [COORD_BITS-1:0] s1_x_q;
  logic [COORD_BITS-1:0] s1_y_q;
  logic [COLOR_W-1:0]    s1_red_q;
  logic [COLOR_W-1:0]    s1_green_q;
  logic [COLOR_W-1:0]    s1_blue_q;

  // Result register stage
  logic                  out_valid_q;
  logic [OFFSET_W-1:0]   offset_q;
  logic [WORD_W-1:0]     word_q;
  logic                  four_q;

  logic out_hold;
  logic in_accept;

  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && out_hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Load the input register on every transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q     <= pixel_x_i;
      s1_y_q     <= pixel_y_i;
      s1_red_q   <= red_in_i;
      s1_green_q <= green_in_i;
      s1_blue_q  <= blue_in_i;
    end
  end

  // Clip against the screen
  logic keep;
  assign keep = (CMP_W'(s1_x_q) < CMP_W'(cfg.screen_width)) &&
                (CMP_W'(s1_y_q) < CMP_W'(cfg.screen_height));

  // Scale and place each colour channel
  logic [WORD_W-1:0] red_placed;
  logic [WORD_W-1:0] green_placed;
  logic [WORD_W-1:0] blue_placed;

  rgbfb_chan u_red (
    .value_i  (s1_red_q),
    .fmt_i    (cfg.red_format),
    .placed_o (red_placed)
  );

  rgbfb_chan u_green (
    .value_i  (s1_green_q),
    .fmt_i    (cfg.green_format),
    .placed_o (green_placed)
  );

  rgbfb_chan u_blue (
    .value_i  (s1_blue_q),
    .fmt_i    (cfg.blue_format),
    .placed_o (blue_placed)
  );

  // Alpha: all ones over its length at its offset, 32 bpp only
  logic [LEN_W-1:0]  alpha_len;
  logic [HALF_W:0]   alpha_ones;
  logic [SH_W-1:0]   alpha_sh;
  logic [WORD_W-1:0] rgb_word;
  logic [WORD_W-1:0] word_d;

  assign alpha_len  = fmt_len(cfg.alpha_format);
  assign alpha_ones = ((HALF_W+1)'(1) << alpha_len) - (HALF_W+1)'(1);
  assign alpha_sh   = SH_W'(alpha_ones[HALF_W-1:0]) << fmt_off(cfg.alpha_format);
  assign rgb_word   = red_placed | green_placed | blue_placed;

  always_comb begin
    if (cfg.bpp_mode) begin
      word_d = rgb_word | alpha_sh[WORD_W-1:0];
    end else begin
      word_d = {{(WORD_W-HALF_W){1'b0}}, rgb_word[HALF_W-1:0]};
    end
  end

  // Byte offset: y*pitch + x*bytes per pixel, wrapped to the offset width
  logic [SUM_W-1:0] x_bytes;
  logic [SUM_W-1:0] offset_sum;

  assign x_bytes    = cfg.bpp_mode ? (SUM_W'(s1_x_q) << 2) : (SUM_W'(s1_x_q) << 1);
  assign offset_sum = SUM_W'(s1_y_q) * SUM_W'(cfg.line_pitch) + x_bytes;

  // Advance into the result register unless the receiver holds it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= s1_valid_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold && s1_valid_q) begin
      offset_q <= offset_sum[OFFSET_W-1:0];
      word_q   <= word_d;
      four_q   <= cfg.bpp_mode;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_offset_o  = offset_q;
  assign packed_pixel_o = word_q;
  assign four_bytes_o   = four_q;

endmodule

@@ hw/rtl/rgbfb_checker.sv @@
module rgbfb_checker import rgbfb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [WORD_W-1:0] packed_pixel_o,
  input logic              four_bytes_o
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input side stalls only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // Two-byte words never carry upper bits
  a_half_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !four_bytes_o |-> packed_pixel_o[WORD_W-1:HALF_W] == '0)
    else $error("upper half set in 16 bpp word");

  // With no transfer and then a free output, the pipe drains: the input register empties, then the result register
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !in_stall_o) ##1 !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result appeared without an accepted pixel");

endmodule

bind rgb888_to_framebuffer_packer_top rgbfb_checker u_checker (.*);
